// File: design/bsbc_pkg.sv
// shared types and constants (opcodes, costs, csr indices) for the bytecode checker
package bsbc_pkg;

   localparam int unsigned MaxSlotsDefault = 65536;
   localparam int unsigned NumRegsDefault  = 11;
   localparam int unsigned QueueDepth      = 2;

   localparam logic [19:0] CostMax = 20'hfffff;

   localparam logic [7:0] OpLddw   = 8'h18;
   localparam logic [7:0] OpCall   = 8'h85;
   localparam logic [7:0] OpExit   = 8'h95;
   localparam logic [7:0] ModeMem  = 8'h60;
   localparam logic [7:0] AluTop   = 8'hd0;
   localparam logic [7:0] OpMovK64 = 8'hb7;
   localparam logic [7:0] OpMovK32 = 8'hb4;
   localparam logic [7:0] OpMovX64 = 8'hbf;
   localparam logic [7:0] OpMovX32 = 8'hbc;
   localparam logic [7:0] OpAddK64 = 8'h07;
   localparam logic [7:0] OpAddK32 = 8'h04;

   localparam logic [19:0] CostHelper1 = 20'd60;
   localparam logic [19:0] CostHelper2 = 20'd12;
   localparam logic [19:0] CostMem     = 20'd4;
   localparam logic [19:0] CostBranch  = 20'd2;
   localparam logic [19:0] CostAlu     = 20'd1;

   localparam logic [2:0] CsrIvarBase  = 3'd0;
   localparam logic [2:0] CsrIvarSize  = 3'd1;
   localparam logic [2:0] CsrStackSize = 3'd2;
   localparam logic [2:0] CsrCeilEn    = 3'd3;
   localparam logic [2:0] CsrCeiling   = 3'd4;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_CONST   = 2'd1,
      KIND_STACK   = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_LOCAL     = 4'd1,
      ST_HELPER    = 4'd2,
      ST_MEM_MODE  = 4'd3,
      ST_LD_FORM   = 4'd4,
      ST_STACK     = 4'd5,
      ST_IVAR      = 4'd6,
      ST_BASE      = 4'd7,
      ST_BACK      = 4'd8,
      ST_ALU       = 4'd9,
      ST_SUBSET    = 4'd10,
      ST_COST      = 4'd11
   } status_type;

   // instruction classes as seen by the back end
   typedef enum logic [3:0] {
      CL_LDDW, CL_CALL, CL_EXIT, CL_MODE_ERR, CL_LDX, CL_ST, CL_LD_FORM,
      CL_MOVK, CL_MOVX, CL_ADDK, CL_BRANCH, CL_ALU_OTHER, CL_ALU_ERR, CL_SUBSET
   } iclass_type;

   typedef struct packed {
      logic [63:0] insn_word;
      logic        last_slot;
   } req_type;

   typedef struct packed {
      logic        final_res;
      logic [3:0]  status;
      logic [19:0] total_cost;
      logic [15:0] fail_slot;
   } rsp_type;

   // classified slot handed from front to back
   typedef struct packed {
      iclass_type  iclass;
      logic [3:0]  dst;
      logic [3:0]  src;
      logic [15:0] off;
      logic [31:0] imm;
      logic        movk64;
      logic        last;
   } slot_type;

   typedef struct packed {
      logic [31:0] ivar_base;
      logic [31:0] ivar_size;
      logic [15:0] stack_bytes;
      logic        ceil_en;
      logic [19:0] ceiling;
   } cfg_type;

endpackage

// File: design/bpf_subset_bytecode_checker.sv
// top level of the ebpf subset bytecode checker
//
// Programs stream in one 8-byte slot per transaction on the req_ channel,
// opcode byte in bits 7..0, with last_slot marking the final slot. Every
// slot gives exactly one transaction on the rsp_ channel: the latched
// status, the running cost and the first failing slot index; the
// transaction for the last slot carries the verdict (final_res set).
// A slot is decoded on entry into a two-entry queue and executed against
// the register table on leaving it, into the registered result. One
// slot per cycle is sustained while the receiver keeps rsp_ready high,
// set by the read-modify-write of the eleven-entry register table.
// If the receiver stalls, the result register holds and the queue fills;
// req_ready falls only once both queue entries are occupied.
// Reset clears the queue, the register table (r10 as stack) and all
// per-program state; configuration returns to its defaults. The csr_
// port writes a register by index and is meant for use only while no
// program is in flight.
module bpf_subset_bytecode_checker #(
   parameter int unsigned MAX_SLOTS = bsbc_pkg::MaxSlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bsbc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bsbc_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import bsbc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_valid, q_ready;
   slot_type q_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CsrIvarBase:  cfg_in.ivar_base   = csr_data;
            CsrIvarSize:  cfg_in.ivar_size   = csr_data;
            CsrStackSize: cfg_in.stack_bytes = csr_data[15:0];
            CsrCeilEn:    cfg_in.ceil_en     = csr_data[0];
            CsrCeiling:   cfg_in.ceiling     = csr_data[19:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ivar_base   <= 32'd0;
         cfg_ff.ivar_size   <= 32'd0;
         cfg_ff.stack_bytes <= 16'd512;
         cfg_ff.ceil_en     <= 1'b0;
         cfg_ff.ceiling     <= 20'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsbc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_data   (q_data)
   );

   bsbc_back #(
      .MAX_SLOTS(MAX_SLOTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_data   (q_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

// File: design/bsbc_front.sv
// front end: decodes and classifies each accepted slot
module bsbc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bsbc_pkg::req_type req_data,
   output logic              q_valid,
   input  logic              q_ready,
   output bsbc_pkg::slot_type q_data
);
   import bsbc_pkg::*;

   logic [7:0] op;
   logic [2:0] cls;
   logic [7:0] mode;
   slot_type   slot;

   assign op   = req_data.insn_word[7:0];
   assign cls  = op[2:0];
   assign mode = op & 8'he0;

   always_comb begin
      slot        = '0;
      slot.dst    = req_data.insn_word[11:8];
      slot.src    = req_data.insn_word[15:12];
      slot.off    = req_data.insn_word[31:16];
      slot.imm    = req_data.insn_word[63:32];
      slot.movk64 = (op == OpMovK64);
      slot.last   = req_data.last_slot;
      if (op == OpLddw) begin
         slot.iclass = CL_LDDW;
      end else if (op == OpCall) begin
         slot.iclass = CL_CALL;
      end else if (op == OpExit) begin
         slot.iclass = CL_EXIT;
      end else if (cls <= 3'd3) begin
         if (mode != ModeMem) begin
            slot.iclass = CL_MODE_ERR;
         end else if (cls == 3'd1) begin
            slot.iclass = CL_LDX;
         end else if (cls == 3'd0) begin
            slot.iclass = CL_LD_FORM;
         end else begin
            slot.iclass = CL_ST;
         end
      end else if (op == OpMovK64 || op == OpMovK32) begin
         slot.iclass = CL_MOVK;
      end else if (op == OpMovX64 || op == OpMovX32) begin
         slot.iclass = CL_MOVX;
      end else if (op == OpAddK64 || op == OpAddK32) begin
         // falls back to a plain alu op in the back end when dst is not constant
         slot.iclass = CL_ADDK;
      end else if (cls == 3'd5 || cls == 3'd6) begin
         slot.iclass = CL_BRANCH;
      end else if (cls == 3'd4 || cls == 3'd7) begin
         slot.iclass = ((op & 8'hf0) > AluTop) ? CL_ALU_ERR : CL_ALU_OTHER;
      end else begin
         slot.iclass = CL_SUBSET;
      end
   end

   bsbc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_valid),
      .in_ready(req_ready),
      .in_data (slot),
      .out_valid(q_valid),
      .out_ready(q_ready),
      .out_data(q_data)
   );

endmodule

// File: design/bsbc_queue.sv
// small fifo between the decode and execute parts
module bsbc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bsbc_pkg::slot_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output bsbc_pkg::slot_type out_data
);
   import bsbc_pkg::*;

   slot_type   mem_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'(QueueDepth));
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: design/bsbc_back.sv
// back end: register tracking, access checks, cost and verdict
module bsbc_back #(
   parameter int unsigned MAX_SLOTS = bsbc_pkg::MaxSlotsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  bsbc_pkg::cfg_type  cfg,
   input  logic               q_valid,
   output logic               q_ready,
   input  bsbc_pkg::slot_type q_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bsbc_pkg::rsp_type  rsp_data
);
   import bsbc_pkg::*;

   localparam int unsigned SlotCapInt = (MAX_SLOTS - 1) < 65535 ? (MAX_SLOTS - 1) : 65535;
   localparam logic [15:0] SlotCap = 16'(SlotCapInt);
   localparam int unsigned NumRegs = NumRegsDefault;

   kind_type    kind_ff  [NumRegs];
   kind_type    kind_in  [NumRegs];
   logic [63:0] value_ff [NumRegs];
   logic [63:0] value_in [NumRegs];
   logic [19:0] cost_ff, cost_in;
   logic [15:0] slot_ff, slot_in;
   logic [3:0]  err_ff, err_in;
   logic [15:0] eslot_ff, eslot_in;
   logic        wl_pend_ff, wl_pend_in;
   logic [3:0]  wl_dst_ff, wl_dst_in;
   logic [31:0] wl_low_ff, wl_low_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        take;
   kind_type    src_kind, dst_kind, base_kind;
   logic [63:0] src_val, base_val;
   logic [3:0]  base_reg;
   logic [63:0] off64, imm64, addr, win_lo, win_hi;
   logic [16:0] neg_off;
   logic        stack_ok, ivar_ok;
   logic [3:0]  acc_err, e;
   logic [19:0] add_c;
   logic [20:0] sum;
   logic [3:0]  status;

   assign q_ready   = !rsp_valid_ff || rsp_ready;
   assign take      = q_valid && q_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      src_kind = (q_data.src < 4'(NumRegs)) ? kind_ff[q_data.src] : KIND_UNKNOWN;
      src_val  = (q_data.src < 4'(NumRegs)) ? value_ff[q_data.src] : 64'd0;
      dst_kind = (q_data.dst < 4'(NumRegs)) ? kind_ff[q_data.dst] : KIND_UNKNOWN;
      base_reg = (q_data.iclass == CL_LDX) ? q_data.src : q_data.dst;
      base_kind = (base_reg < 4'(NumRegs)) ? kind_ff[base_reg] : KIND_UNKNOWN;
      base_val  = (base_reg < 4'(NumRegs)) ? value_ff[base_reg] : 64'd0;
      off64 = {{48{q_data.off[15]}}, q_data.off};
      imm64 = {{32{q_data.imm[31]}}, q_data.imm};
      // off in [-frame, -1]: negative and -off <= frame
      neg_off  = 17'd0 - {q_data.off[15], q_data.off};
      stack_ok = q_data.off[15] && (neg_off <= {1'b0, cfg.stack_bytes});
      addr   = base_val + off64;
      win_lo = {32'd0, cfg.ivar_base};
      win_hi = win_lo + {32'd0, cfg.ivar_size};
      ivar_ok = (addr >= win_lo) && (addr < win_hi);
      case (base_kind)
         KIND_STACK: acc_err = stack_ok ? ST_OK : ST_STACK;
         KIND_CONST: acc_err = ivar_ok ? ST_OK : ST_IVAR;
         default:    acc_err = ST_BASE;
      endcase
   end

   always_comb begin
      for (int r = 0; r < NumRegs; r++) begin
         kind_in[r]  = kind_ff[r];
         value_in[r] = value_ff[r];
      end
      cost_in    = cost_ff;
      slot_in    = slot_ff;
      err_in     = err_ff;
      eslot_in   = eslot_ff;
      wl_pend_in = wl_pend_ff;
      wl_dst_in  = wl_dst_ff;
      wl_low_in  = wl_low_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in     = rsp_ff;
      e          = ST_OK;
      add_c      = 20'd0;
      sum        = 21'd0;
      status     = ST_OK;

      if (take) begin
         if (err_ff == ST_OK) begin
            if (wl_pend_ff) begin
               wl_pend_in = 1'b0;
               if (wl_dst_ff < 4'(NumRegs)) begin
                  kind_in[wl_dst_ff]  = KIND_CONST;
                  value_in[wl_dst_ff] = {q_data.imm, wl_low_ff};
               end
            end else begin
               case (q_data.iclass)
                  CL_LDDW: begin
                     wl_pend_in = 1'b1;
                     wl_dst_in  = q_data.dst;
                     wl_low_in  = q_data.imm;
                     add_c      = CostBranch;
                  end
                  CL_CALL: begin
                     if (q_data.src == 4'd1) begin
                        e = ST_LOCAL;
                     end else if (q_data.imm != 32'd1 && q_data.imm != 32'd2) begin
                        e = ST_HELPER;
                     end else begin
                        for (int r = 0; r <= 5; r++) begin
                           kind_in[r]  = KIND_UNKNOWN;
                           value_in[r] = 64'd0;
                        end
                        add_c = (q_data.imm == 32'd1) ? CostHelper1 : CostHelper2;
                     end
                  end
                  CL_EXIT:     e = ST_OK;
                  CL_MODE_ERR: e = ST_MEM_MODE;
                  CL_LDX: begin
                     add_c = CostMem;
                     e     = acc_err;
                     if (acc_err == ST_OK && q_data.dst < 4'(NumRegs)) begin
                        kind_in[q_data.dst]  = KIND_UNKNOWN;
                        value_in[q_data.dst] = 64'd0;
                     end
                  end
                  CL_ST: begin
                     add_c = CostMem;
                     e     = acc_err;
                  end
                  CL_LD_FORM: begin
                     add_c = CostMem;
                     e     = ST_LD_FORM;
                  end
                  CL_MOVK: begin
                     add_c = CostAlu;
                     if (q_data.dst < 4'(NumRegs)) begin
                        kind_in[q_data.dst]  = KIND_CONST;
                        value_in[q_data.dst] = q_data.movk64 ? imm64 : {32'd0, q_data.imm};
                     end
                  end
                  CL_MOVX: begin
                     add_c = CostAlu;
                     if (q_data.dst < 4'(NumRegs)) begin
                        kind_in[q_data.dst]  = src_kind;
                        value_in[q_data.dst] = src_val;
                     end
                  end
                  CL_ADDK, CL_ALU_OTHER: begin
                     add_c = CostAlu;
                     if (q_data.dst < 4'(NumRegs)) begin
                        if (q_data.iclass == CL_ADDK && dst_kind == KIND_CONST) begin
                           value_in[q_data.dst] = value_ff[q_data.dst] + imm64;
                        end else begin
                           kind_in[q_data.dst]  = KIND_UNKNOWN;
                           value_in[q_data.dst] = 64'd0;
                        end
                     end
                  end
                  CL_BRANCH: begin
                     if (q_data.off[15]) begin
                        e = ST_BACK;
                     end else begin
                        add_c = CostBranch;
                     end
                  end
                  CL_ALU_ERR: e = ST_ALU;
                  default:    e = ST_SUBSET;
               endcase
               // cost counts for a memory op even when its access fails
               sum = {1'b0, cost_ff} + {1'b0, add_c};
               cost_in = sum[20] ? CostMax : sum[19:0];
               if (e != ST_OK) begin
                  err_in   = e;
                  eslot_in = slot_ff;
               end
            end
         end

         status = err_in;
         if (q_data.last && err_in == ST_OK && cfg.ceil_en && cost_in > cfg.ceiling) begin
            status = ST_COST;
         end
         rsp_valid_in         = 1'b1;
         rsp_in.final_res     = q_data.last;
         rsp_in.status        = status;
         rsp_in.total_cost    = cost_in;
         rsp_in.fail_slot     = (err_in != ST_OK) ? eslot_in : 16'd0;

         if (q_data.last) begin
            // a trailing wide load leaves nothing visible once state is cleared
            for (int r = 0; r < NumRegs; r++) begin
               kind_in[r]  = KIND_UNKNOWN;
               value_in[r] = 64'd0;
            end
            kind_in[NumRegs-1] = KIND_STACK;
            cost_in    = 20'd0;
            slot_in    = 16'd0;
            err_in     = ST_OK;
            eslot_in   = 16'd0;
            wl_pend_in = 1'b0;
            wl_dst_in  = 4'd0;
            wl_low_in  = 32'd0;
         end else if (slot_ff < SlotCap) begin
            slot_in = slot_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NumRegs; r++) begin
            kind_ff[r]  <= KIND_UNKNOWN;
            value_ff[r] <= 64'd0;
         end
         kind_ff[NumRegs-1] <= KIND_STACK;
         cost_ff      <= 20'd0;
         slot_ff      <= 16'd0;
         err_ff       <= ST_OK;
         eslot_ff     <= 16'd0;
         wl_pend_ff   <= 1'b0;
         wl_dst_ff    <= 4'd0;
         wl_low_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int r = 0; r < NumRegs; r++) begin
            kind_ff[r]  <= kind_in[r];
            value_ff[r] <= value_in[r];
         end
         cost_ff      <= cost_in;
         slot_ff      <= slot_in;
         err_ff       <= err_in;
         eslot_ff     <= eslot_in;
         wl_pend_ff   <= wl_pend_in;
         wl_dst_ff    <= wl_dst_in;
         wl_low_ff    <= wl_low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// File: tb/sv/bpf_subset_bytecode_checker_test.sv
// testbench for the ebpf subset bytecode checker: directed table then random programs
`timescale 1ns / 1ps

module bpf_subset_bytecode_checker_test;
   import bsbc_pkg::*;

   localparam logic [2:0] ClsLdx = 3'd1;
   localparam logic [2:0] ClsSt  = 3'd2;
   localparam logic [2:0] ClsStx = 3'd3;
   localparam logic [2:0] ClsJmp = 3'd5;
   localparam logic [2:0] ClsJmp32 = 3'd6;
   localparam logic [2:0] ClsAlu = 3'd4;
   localparam logic [2:0] ClsAlu64 = 3'd7;
   localparam int unsigned RunLimit = 400000;

   typedef struct {
      logic [63:0] word;
      logic        last;
      logic        typed;
      rsp_type     res;
   } dir_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_write;
   logic [2:0] csr_index;
   logic [31:0] csr_data;

   // checker state as tracked by the testbench
   logic [31:0] ivar_base_q;
   logic [31:0] ivar_size_q;
   logic [15:0] stack_bytes_q;
   logic        ceil_en_q;
   logic [19:0] ceiling_q;
   kind_type    kind_q [11];
   logic [63:0] value_q [11];
   logic [19:0] cost_q;
   logic [15:0] slot_q;
   logic [3:0]  err_q;
   logic [15:0] err_slot_q;
   logic        wide_pend_q;
   logic [3:0]  wide_dest_q;
   logic [31:0] wide_low_q;

   rsp_type     pending_results [$];
   dir_row_type dir_rows [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   bit          hold_long = 0;
   bit          no_gaps = 0;

   bpf_subset_bytecode_checker dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_program();
      for (int r = 0; r < 11; r++) begin
         kind_q[r] = KIND_UNKNOWN;
         value_q[r] = '0;
      end
      kind_q[10] = KIND_STACK;
      cost_q = '0;
      slot_q = '0;
      err_q = ST_OK;
      err_slot_q = '0;
      wide_pend_q = 0;
      wide_dest_q = '0;
      wide_low_q = '0;
   endfunction

   function automatic void add_cost(logic [19:0] c);
      logic [20:0] s;
      s = {1'b0, cost_q} + {1'b0, c};
      cost_q = s[20] ? CostMax : s[19:0];
   endfunction

   function automatic void write_reg(logic [3:0] r, kind_type k, logic [63:0] v);
      if (r < 11) begin
         kind_q[r] = k;
         value_q[r] = v;
      end
   endfunction

   function automatic logic [3:0] access_status(logic [3:0] b, int off);
      kind_type k;
      logic [63:0] addr, lo, hi;
      k = (b < 11) ? kind_q[b] : KIND_UNKNOWN;
      if (k == KIND_STACK) begin
         if (off < -int'({16'b0, stack_bytes_q}) || off >= 0) return ST_STACK;
         return ST_OK;
      end
      if (k == KIND_CONST) begin
         addr = value_q[b] + 64'(longint'(off));
         lo = {32'b0, ivar_base_q};
         hi = lo + {32'b0, ivar_size_q};
         return (addr >= lo && addr < hi) ? ST_OK : ST_IVAR;
      end
      return ST_BASE;
   endfunction

   function automatic logic [3:0] slot_status(logic [63:0] w);
      logic [7:0] op;
      logic [3:0] dst, src, e;
      logic [2:0] cls;
      logic [31:0] imm;
      logic [63:0] imm64;
      int off;
      op = w[7:0];
      dst = w[11:8];
      src = w[15:12];
      off = int'(signed'(w[31:16]));
      imm = w[63:32];
      imm64 = {{32{imm[31]}}, imm};
      cls = op[2:0];
      if (op == OpLddw) begin
         wide_pend_q = 1;
         wide_dest_q = dst;
         wide_low_q = imm;
         add_cost(CostBranch);
         return ST_OK;
      end
      if (op == OpCall) begin
         if (src == 4'd1) return ST_LOCAL;
         if (imm != 32'd1 && imm != 32'd2) return ST_HELPER;
         for (int r = 0; r <= 5; r++) begin
            kind_q[r] = KIND_UNKNOWN;
            value_q[r] = '0;
         end
         add_cost(imm == 32'd1 ? CostHelper1 : CostHelper2);
         return ST_OK;
      end
      if (op == OpExit) return ST_OK;
      if (cls <= ClsStx) begin
         if ((op & 8'he0) != ModeMem) return ST_MEM_MODE;
         add_cost(CostMem);
         if (cls == ClsLdx) begin
            e = access_status(src, off);
            if (e != ST_OK) return e;
            write_reg(dst, KIND_UNKNOWN, '0);
            return ST_OK;
         end
         if (cls == ClsSt || cls == ClsStx) return access_status(dst, off);
         return ST_LD_FORM;
      end
      if (op == OpMovK64 || op == OpMovK32) begin
         write_reg(dst, KIND_CONST, op == OpMovK64 ? imm64 : {32'b0, imm});
         add_cost(CostAlu);
         return ST_OK;
      end
      if (op == OpMovX64 || op == OpMovX32) begin
         write_reg(dst, (src < 11) ? kind_q[src] : KIND_UNKNOWN,
                   (src < 11) ? value_q[src] : 64'b0);
         add_cost(CostAlu);
         return ST_OK;
      end
      if ((op == OpAddK64 || op == OpAddK32) && dst < 11 && kind_q[dst] == KIND_CONST) begin
         value_q[dst] = value_q[dst] + imm64;
         add_cost(CostAlu);
         return ST_OK;
      end
      if (cls == ClsJmp || cls == ClsJmp32) begin
         if (off < 0) return ST_BACK;
         add_cost(CostBranch);
         return ST_OK;
      end
      if (cls == ClsAlu || cls == ClsAlu64) begin
         if ((op & 8'hf0) > AluTop) return ST_ALU;
         write_reg(dst, KIND_UNKNOWN, '0);
         add_cost(CostAlu);
         return ST_OK;
      end
      return ST_SUBSET;
   endfunction

   function automatic rsp_type check_slot_result(logic [63:0] w, logic last);
      rsp_type res;
      logic [3:0] e;
      if (err_q == ST_OK) begin
         if (wide_pend_q) begin
            wide_pend_q = 0;
            write_reg(wide_dest_q, KIND_CONST, {w[63:32], wide_low_q});
         end else begin
            e = slot_status(w);
            if (e != ST_OK) begin
               err_q = e;
               err_slot_q = slot_q;
            end
         end
      end
      res.final_res = last;
      res.status = err_q;
      res.total_cost = cost_q;
      res.fail_slot = (err_q != ST_OK) ? err_slot_q : 16'd0;
      if (last && err_q == ST_OK && ceil_en_q && cost_q > ceiling_q) res.status = ST_COST;
      if (last) clear_program();
      else if (slot_q != 16'hffff) slot_q++;
      return res;
   endfunction

   function automatic logic [63:0] encode(logic [7:0] op, logic [3:0] dst, logic [3:0] src,
                                          logic [15:0] off, logic [31:0] imm);
      return {imm, off, src, dst, op};
   endfunction

   // send one slot; the expectation is queued when the transaction is taken
   task automatic send_slot(logic [63:0] w, logic last, logic typed, rsp_type typed_res);
      int unsigned pick, gap;
      rsp_type res;
      pick = $urandom_range(0, 99);
      gap = (no_gaps || pick < 60) ? 0 : (pick < 92 ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 30));
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{insn_word: w, last_slot: last};
      do @(posedge clock); while (!req_ready);
      res = check_slot_result(w, last);
      pending_results.push_back(typed ? typed_res : res);
      items_sent++;
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      case (idx)
         CsrIvarBase:  ivar_base_q = val;
         CsrIvarSize:  ivar_size_q = val;
         CsrStackSize: stack_bytes_q = val[15:0];
         CsrCeilEn:    ceil_en_q = val[0];
         CsrCeiling:   ceiling_q = val[19:0];
         default: ;
      endcase
   endtask

   task automatic setup(logic [31:0] base, logic [31:0] size, logic [15:0] stack,
                        logic en, logic [19:0] ceil);
      req_valid <= 0;
      wait (pending_results.size() == 0);
      repeat (4) @(posedge clock);
      write_csr(CsrIvarBase, base);
      write_csr(CsrIvarSize, size);
      write_csr(CsrStackSize, {16'b0, stack});
      write_csr(CsrCeilEn, {31'b0, en});
      write_csr(CsrCeiling, {12'b0, ceil});
      csr_write <= 0;
      @(posedge clock);
   endtask

   function automatic logic [3:0] any_reg();
      return ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10));
   endfunction

   function automatic logic [15:0] stack_offset();
      case ($urandom_range(0, 5))
         0: return 16'(-int'($urandom_range(1, 8)));
         1: return 16'(-int'({16'b0, stack_bytes_q}));
         2: return 16'(-int'({16'b0, stack_bytes_q}) - 1);
         3: return 16'($urandom_range(0, 8));
         default: return 16'(-int'($urandom_range(1, {16'b0, stack_bytes_q})));
      endcase
   endfunction

   // one program with random content, mostly well formed
   task automatic run_program();
      logic [63:0] words [$];
      logic [63:0] w;
      logic [31:0] addr;
      logic [3:0] b;
      logic [7:0] op;
      int unsigned len, pick;
      rsp_type none;
      none = '0;
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
         addr = ivar_base_q + ($urandom_range(0, 3) == 0 ? $urandom
                                                         : $urandom_range(0, 64));
         words.push_back(encode(OpLddw, 4'd1, 4'd0, 16'd0, addr));
         words.push_back(encode(8'h00, 4'd0, 4'd0, 16'd0,
                                $urandom_range(0, 7) == 0 ? $urandom : 32'd0));
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 29);
         b = $urandom_range(0, 1) ? 4'd10 : ($urandom_range(0, 1) ? 4'd1 : any_reg());
         case (pick)
            0, 1: w = encode($urandom_range(0, 1) ? OpMovK64 : OpMovK32, any_reg(),
                             4'($urandom), 16'($urandom), $urandom);
            2, 3: w = encode($urandom_range(0, 1) ? OpMovX64 : OpMovX32, any_reg(),
                             any_reg(), 16'($urandom), $urandom);
            4: w = encode($urandom_range(0, 1) ? OpAddK64 : OpAddK32, 4'd1, 4'($urandom),
                          16'($urandom), 32'($urandom_range(0, 8)));
            5, 6, 7, 8: w = encode(ModeMem | {3'b0, 2'($urandom), ClsLdx}, any_reg(), b,
                                  b == 4'd10 ? stack_offset() : 16'($urandom_range(0, 16) - 8),
                                  $urandom);
            9, 10, 11: w = encode(ModeMem | {3'b0, 2'($urandom),
                                  $urandom_range(0, 1) ? ClsSt : ClsStx}, b, 4'($urandom),
                                  b == 4'd10 ? stack_offset() : 16'($urandom_range(0, 16) - 8),
                                  $urandom);
            12, 13: begin
               words.push_back(encode(OpLddw, any_reg(), 4'($urandom), 16'($urandom), $urandom));
               w = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'(0);
            end
            14, 15: w = encode(OpCall, 4'($urandom), $urandom_range(0, 9) == 0 ? 4'd1 : 4'd0,
                               16'($urandom), $urandom_range(0, 7) == 0 ? $urandom
                                                               : 32'($urandom_range(1, 2)));
            16, 17, 18: w = encode({4'($urandom), 1'($urandom),
                                   $urandom_range(0, 1) ? ClsJmp : ClsJmp32},
                                   4'($urandom), 4'($urandom),
                                   $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 99)),
                                   $urandom);
            19, 20, 21, 22: w = encode({4'($urandom_range(0, 15)), 1'($urandom),
                                       $urandom_range(0, 1) ? ClsAlu : ClsAlu64},
                                       any_reg(), any_reg(), 16'($urandom), $urandom);
            23: w = encode(OpExit, 4'($urandom), 4'($urandom), 16'($urandom), $urandom);
            24: begin
               op = {3'($urandom), 2'($urandom), 3'($urandom_range(0, 3))};
               w = encode(op, any_reg(), any_reg(), 16'($urandom), $urandom);
            end
            default: w = {$urandom, $urandom};
         endcase
         words.push_back(w);
      end
      if ($urandom_range(0, 9) == 0)
         words.push_back(encode(OpLddw, any_reg(), 4'd0, 16'd0, $urandom));
      else
         words.push_back(encode(OpExit, 4'd0, 4'd0, 16'd0, 32'd0));
      foreach (words[i]) send_slot(words[i], i == words.size() - 1, 0, none);
   endtask

   task automatic add_row(logic [63:0] w, logic last, logic typed, rsp_type res);
      dir_rows.push_back('{word: w, last: last, typed: typed, res: res});
   endtask

   // whole programs until about count more slots have gone in
   task automatic random_phase(int unsigned count);
      int unsigned stop;
      stop = items_sent + count;
      while (items_sent < stop) run_program();
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_write = 0;
      csr_index = CsrIvarBase;
      csr_data = '0;
      ivar_base_q = '0;
      ivar_size_q = '0;
      stack_bytes_q = 16'd512;
      ceil_en_q = 0;
      ceiling_q = '0;
      clear_program();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      add_row(encode(OpExit, 4'd0, 4'd0, 16'd0, 32'd0), 1, 1, {1'b1, ST_OK, 20'd0, 16'd0});
      add_row(encode(OpMovK64, 4'd0, 4'd0, 16'd0, 32'h7fffffff), 0, 0, '0);
      add_row(encode(OpExit, 4'd0, 4'd0, 16'd0, 32'd0), 1, 1, {1'b1, ST_OK, 20'd1, 16'd0});
      add_row(encode(OpCall, 4'd0, 4'd0, 16'd0, 32'd3), 1, 1, {1'b1, ST_HELPER, 20'd0, 16'd0});
      add_row(encode(OpCall, 4'd0, 4'd1, 16'd0, 32'd1), 1, 1, {1'b1, ST_LOCAL, 20'd0, 16'd0});
      add_row(encode(ModeMem, 4'd0, 4'd0, 16'd0, 32'd0), 1, 1, {1'b1, ST_LD_FORM, 20'd4, 16'd0});
      add_row(encode(8'h01, 4'd0, 4'd0, 16'd0, 32'd0), 1, 1, {1'b1, ST_MEM_MODE, 20'd0, 16'd0});
      add_row(encode(8'h79, 4'd0, 4'd10, 16'hfe00, 32'd0), 1, 1, {1'b1, ST_OK, 20'd4, 16'd0});
      add_row(encode(8'h79, 4'd0, 4'd10, 16'h0000, 32'd0), 1, 1, {1'b1, ST_STACK, 20'd4, 16'd0});
      add_row(encode(8'h7b, 4'd1, 4'd2, 16'hffff, 32'd0), 1, 1, {1'b1, ST_BASE, 20'd4, 16'd0});
      add_row(encode(8'h05, 4'd0, 4'd0, 16'hffff, 32'd0), 1, 1, {1'b1, ST_BACK, 20'd0, 16'd0});
      add_row(encode(8'he7, 4'd0, 4'd0, 16'd0, 32'd0), 1, 1, {1'b1, ST_ALU, 20'd0, 16'd0});
      add_row(encode(OpLddw, 4'd2, 4'd0, 16'd0, 32'hffffffff), 0, 0, '0);
      add_row({32'hffffffff, 32'hffffffff}, 0, 0, '0);
      add_row(encode(8'h79, 4'd0, 4'd2, 16'h7fff, 32'd0), 1, 0, '0);
      add_row(encode(OpLddw, 4'd3, 4'd0, 16'd0, 32'h80000000), 1, 0, '0);
      add_row(encode(OpMovX64, 4'd3, 4'd15, 16'd0, 32'd0), 0, 0, '0);
      add_row(encode(8'h7b, 4'd3, 4'd0, 16'hfff8, 32'd0), 1, 0, '0);
      add_row(encode(OpMovK64, 4'd15, 4'd0, 16'd0, 32'h80000000), 1, 0, '0);
      add_row(encode(OpCall, 4'd0, 4'd0, 16'd0, 32'd1), 0, 0, '0);
      add_row(encode(OpCall, 4'd0, 4'd0, 16'd0, 32'd2), 1, 1, {1'b1, ST_OK, 20'd72, 16'd0});
      add_row(encode(OpMovK32, 4'd0, 4'd0, 16'd0, 32'd1), 0, 0, '0);
      add_row(encode(OpMovK32, 4'd1, 4'd0, 16'd0, 32'd1), 0, 0, '0);
      add_row(encode(OpCall, 4'd0, 4'd0, 16'd0, 32'd3), 1, 1, {1'b1, ST_HELPER, 20'd2, 16'd2});
      foreach (dir_rows[i]) send_slot(dir_rows[i].word, dir_rows[i].last,
                                      dir_rows[i].typed, dir_rows[i].res);
      random_phase(200);

      setup(32'h1000_0000, 32'h100, 16'd1, 1, 20'd0);
      hold_long = 1;
      random_phase(250);
      setup(32'hffff_ff00, 32'hffff_ffff, 16'd32768, 1, 20'd50);
      random_phase(250);
      setup(32'h0, 32'hffff_ffff, 16'd512, 0, 20'hfffff);
      random_phase(230);

      req_valid <= 0;
      wait (pending_results.size() == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // result side: random stalls, and one long hold-off so the input backs up
   initial begin
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         int unsigned pick;
         pick = $urandom_range(0, 99);
         if (hold_long) begin
            rsp_ready <= 0;
            for (int n = 0; n < 80; n++) @(posedge clock);
            hold_long = 0;
         end else if (pick < 65) begin
            rsp_ready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 0;
            repeat (pick < 95 ? $urandom_range(1, 3) : $urandom_range(10, 30)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with nothing expected: %h", rsp_data);
            mismatch_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_data.final_res !== exp_res.final_res) begin
               $error("final_res expected %0d got %0d", exp_res.final_res, rsp_data.final_res);
               mismatch_count++;
            end
            if (rsp_data.status !== exp_res.status) begin
               $error("status expected %0d got %0d", exp_res.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.total_cost !== exp_res.total_cost) begin
               $error("total_cost expected %0d got %0d", exp_res.total_cost,
                      rsp_data.total_cost);
               mismatch_count++;
            end
            if (rsp_data.fail_slot !== exp_res.fail_slot) begin
               $error("fail_slot expected %0d got %0d", exp_res.fail_slot, rsp_data.fail_slot);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RunLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
